>>> sv/spn_block_cipher_128_unit_defines.svh
// Assertion macros shared by the cipher unit.
// Depends on nothing; included by the top level.
`ifndef SPN_BLOCK_CIPHER_128_UNIT_DEFINES_SVH
`define SPN_BLOCK_CIPHER_128_UNIT_DEFINES_SVH
`define SPN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SPN_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> sv/spn_pkg.sv
`timescale 1ns / 1ps
// Types, S-box tables and bit transposes for the SPN cipher.
// Depends on nothing.
package spn_pkg;
    localparam int BlockW = 128;
    localparam int KeyW = 176;
    typedef logic [BlockW-1:0] t_block;
    typedef logic [KeyW-1:0] t_key;
    typedef enum logic [1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_MID  = 2'd1,
        CFG_KEY_LOW  = 2'd2
    } t_cfg_idx;
    typedef struct packed {
        logic   vld;
        logic   func;
        t_block data;
    } t_stage;

    localparam logic [7:0] SBOX_FWD [256] = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    localparam logic [7:0] SBOX_INV [256] = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic t_block sub_bytes(input t_block x, input logic inv);
        t_block r;
        for (int i = 0; i < 16; i++) begin
            r[8*i +: 8] = inv ? SBOX_INV[x[8*i +: 8]] : SBOX_FWD[x[8*i +: 8]];
        end
        return r;
    endfunction

    // Bit k counts from the MSB, so it sits at vector position 127-k.
    function automatic t_block transpose(input t_block x, input logic inv);
        t_block r;
        for (int k = 0; k < 128; k++) begin
            if (inv) begin
                r[127-k] = x[127 - (16*(k%8) + k/8)];
            end else begin
                r[127-k] = x[127 - (8*(k%16) + k/16)];
            end
        end
        return r;
    endfunction

    // Round key r is key nibbles r to r+31; nibbles past the key read as zero.
    function automatic t_block round_key(input t_key key, input int r);
        logic [KeyW+BlockW-1:0] ext;
        ext = {key, {BlockW{1'b0}}};
        return ext[KeyW+BlockW-1-4*r -: BlockW];
    endfunction
endpackage

>>> sv/spn_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for blocks and configuration writes.
// Depends on nothing.
interface spn_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    modport source (output valid, func, block_hi, block_lo, input ready);
    modport sink (input valid, func, block_hi, block_lo, output ready);
endinterface

interface spn_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    modport source (output valid, result_hi, result_lo, input ready);
    modport sink (input valid, result_hi, result_lo, output ready);
endinterface

interface spn_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/spn_block_cipher_128_unit.sv
`timescale 1ns / 1ps
// Top level of the 128-bit SPN cipher: key registers and the round-cell chain.
// Depends on spn_pkg, spn_stream_if, spn_round_cell and the defines header.
// Usage: blocks enter on the input channel with func (0 encrypt, 1 decrypt);
// results leave in order on the output channel. The key is written through
// the configuration channel (index 0 high, 1 mid, 2 low); the user must write
// it only while idle, as the block does not enforce this. One cell per round,
// each with its own register, so a transaction passes ROUNDS cells and is
// registered in each. The chain takes one block per cycle as long as the output
// side accepts. When the receiver stalls and the last cell holds a result, that
// cell holds while earlier cells still advance and fill bubbles; input ready drops
// only once every cell is full. Reset clears the key to zero and empties the chain.
`include "spn_block_cipher_128_unit_defines.svh"
module spn_block_cipher_128_unit #(
    parameter int ROUNDS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spn_cfg_if.sink   cfg,
    spn_in_if.sink    in_ch,
    spn_out_if.source out_ch
);
    logic [63:0] r_key_high;
    logic [63:0] r_key_mid;
    logic [47:0] r_key_low;
    spn_pkg::t_key key;
    spn_pkg::t_stage chain [ROUNDS+1];
    logic [ROUNDS-1:0] en;

    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_mid  <= '0;
            r_key_low  <= '0;
        end else if (cfg.valid) begin
            case (cfg.index)
                spn_pkg::CFG_KEY_HIGH: r_key_high <= cfg.data;
                spn_pkg::CFG_KEY_MID:  r_key_mid  <= cfg.data;
                spn_pkg::CFG_KEY_LOW:  r_key_low  <= cfg.data[47:0];
                default: ;
            endcase
        end
    end
    assign key = {r_key_high, r_key_mid, r_key_low};

    assign chain[0].vld  = in_ch.valid;
    assign chain[0].func = in_ch.func;
    assign chain[0].data = {in_ch.block_hi, in_ch.block_lo};

    // A cell advances when its own register is empty or its downstream side accepts.
    always_comb begin
        en[ROUNDS-1] = out_ch.ready || !chain[ROUNDS].vld;
        for (int i = ROUNDS - 2; i >= 0; i--) begin
            en[i] = en[i+1] || !chain[i+1].vld;
        end
    end

    for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
        spn_round_cell #(.ROUNDS(ROUNDS), .POS(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[g]),
            .i_key   (key),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    assign in_ch.ready      = en[0];
    assign out_ch.valid     = chain[ROUNDS].vld;
    assign out_ch.result_hi = chain[ROUNDS].data[127:64];
    assign out_ch.result_lo = chain[ROUNDS].data[63:0];

    `SPN_ASSERT(a_stall_hold, i_clk, i_rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_hi), "stalled result changed")
    `SPN_ASSERT(a_ready_full, i_clk, i_rst_n, !in_ch.ready |-> out_ch.valid && !out_ch.ready, "ready low without a stall")
    `SPN_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !out_ch.valid, "chain not empty after reset")
endmodule

>>> sv/spn_round_cell.sv
`timescale 1ns / 1ps
// One round cell of the cipher pipeline with its stage register.
// Depends on spn_pkg.
module spn_round_cell #(
    parameter int ROUNDS = 10,
    parameter int POS = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  spn_pkg::t_key   i_key,
    input  spn_pkg::t_stage i_stage,
    output spn_pkg::t_stage o_stage
);
    spn_pkg::t_stage r_stage;
    spn_pkg::t_stage n_stage;
    spn_pkg::t_block enc;
    spn_pkg::t_block dec;

    // Encryption runs round POS; decryption runs round ROUNDS-1-POS.
    always_comb begin
        enc = spn_pkg::sub_bytes(i_stage.data ^ spn_pkg::round_key(i_key, POS), 1'b0);
        if (POS < ROUNDS - 1) begin
            enc = spn_pkg::transpose(enc, 1'b0);
        end else begin
            enc = enc ^ spn_pkg::round_key(i_key, ROUNDS);
        end
        dec = i_stage.data;
        if (POS == 0) begin
            dec = dec ^ spn_pkg::round_key(i_key, ROUNDS);
        end else begin
            dec = spn_pkg::transpose(dec, 1'b1);
        end
        dec = spn_pkg::sub_bytes(dec, 1'b1) ^ spn_pkg::round_key(i_key, ROUNDS - 1 - POS);
        n_stage.vld  = i_stage.vld;
        n_stage.func = i_stage.func;
        n_stage.data = i_stage.func ? dec : enc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else if (i_en) begin
            r_stage.vld <= n_stage.vld;
        end
        if (i_en) begin
            r_stage.func <= n_stage.func;
            r_stage.data <= n_stage.data;
        end
    end

    assign o_stage = r_stage;
endmodule
